FILE: rtl/tfq_pkg.sv
// ----------------------------------------------------------------------------
// tfq_pkg: shared types and codes for the timestamped queue
// Holds the request, response, entry and cell control types, together with
// the mode, status and cell operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tfq_pkg;

    // Wide enough for any cell position at the largest supported depth
    localparam int POS_W = 8;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_PEEK  = 2'd2;
    localparam logic [1:0] MODE_PURGE = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_PUSH  = 2'd1;
    localparam logic [1:0] CELL_SHIFT = 2'd2;
    localparam logic [1:0] CELL_PURGE = 2'd3;

    typedef struct packed {
        logic [31:0] arrival;
        logic [15:0] articles;
    } tfq_entry_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] arrival_time;
        logic [15:0] article_count;
        logic [31:0] now_time;
    } tfq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] head_arrival;
        logic [15:0] head_articles;
        logic [4:0]  queue_length;
        logic [3:0]  removed_count;
    } tfq_rsp_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic             survive;
    } tfq_cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tfq_stream_if.sv
// ----------------------------------------------------------------------------
// tfq_stream_if: valid/ready channel
// Carries one payload per transfer; a transfer completes on a rising clock
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/timestamped_fifo_with_expiry_purge.sv
// ----------------------------------------------------------------------------
// timestamped_fifo_with_expiry_purge: ordered queue with timeout purge
// Compacted queue of timestamped entries built as a row of cells, head in
// cell 0, with push, pop, peek and purge of expired non-head entries.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one transfer per operation (mode, arrival_time, article_count,
//          now_time). rsp : exactly one transfer per request with status,
//          head fields, queue length after the operation and purge count.
//   cfg  : write of max_wait; take it only while the block is idle.
// Response timing and throughput:
//   Push, pop and peek update the queue at the request transfer; the response
//   is registered and shows up the cycle after the request transfer. A new
//   request is taken in the same cycle the previous response is taken, so
//   while the receiver keeps rsp.ready high these run at one per cycle.
//   Purge on a queue of N >= 2 entries enters a purge state: the row of cells
//   rotates the non-head entries once past cell 1, where each one is checked
//   against max_wait and either re-enters at the tail or drops out. With
//   fewer than two entries a purge does no rotation and answers at once.
// Reset: queue empty, max_wait cleared, no response pending.
// Stall: while a response waits for the receiver, req.ready stays low unless
//   that response is taken in the same cycle; queue contents hold.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_fifo_with_expiry_purge #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    tfq_stream_if.sink     req,
    tfq_stream_if.source   rsp,
    tfq_stream_if.sink     cfg
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PURGE = 1'b1;

    // Controller state
    logic                state_reg;
    logic                state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    removed_reg;
    logic [CNT_W-1:0]    removed_next;
    logic [CNT_W-1:0]    step_reg;
    logic [CNT_W-1:0]    step_next;
    logic [31:0]         now_reg;
    logic [31:0]         now_next;
    logic [31:0]         max_wait_reg;

    // Response register
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    tfq_pkg::tfq_rsp_t   rsp_data_reg;
    tfq_pkg::tfq_rsp_t   rsp_data_next;

    logic                req_fire;
    logic                rsp_load;
    logic                survive;
    logic [31:0]         wait_time;
    tfq_pkg::tfq_cell_ctl_t ctl;
    tfq_pkg::tfq_entry_t push_data;
    tfq_pkg::tfq_entry_t cell_q [QUEUE_DEPTH];

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

    // Configuration: accept every write, update max_wait
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_wait_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_wait_reg <= cfg.payload;
        end
    end

    assign push_data.arrival  = req.payload.arrival_time;
    assign push_data.articles = req.payload.article_count;

    // Expiry check on the entry currently sitting in cell 1 (wraps mod 2^32)
    assign wait_time = now_reg - cell_q[1].arrival;
    assign survive   = wait_time < max_wait_reg;

    always_comb
    begin
        tfq_pkg::tfq_rsp_t rsp_new;
        rsp_new        = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        removed_next   = removed_reg;
        step_next      = step_reg;
        now_next       = now_reg;
        rsp_load       = 1'b0;
        ctl.op         = tfq_pkg::CELL_HOLD;
        ctl.pos        = '0;
        ctl.survive    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_load = 1'b1;
                    unique case (req.payload.mode)
                        tfq_pkg::MODE_PUSH:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                // drop the entry, report full
                                rsp_new.status = tfq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ctl.op     = tfq_pkg::CELL_PUSH;
                                ctl.pos    = tfq_pkg::POS_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        tfq_pkg::MODE_POP,
                        tfq_pkg::MODE_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_new.status = tfq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_new.head_arrival  = cell_q[0].arrival;
                                rsp_new.head_articles = cell_q[0].articles;
                                if (req.payload.mode == tfq_pkg::MODE_POP)
                                begin
                                    // advance every cell toward the head
                                    ctl.op     = tfq_pkg::CELL_SHIFT;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        tfq_pkg::MODE_PURGE:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                // start the rotation; answer when it ends
                                rsp_load     = 1'b0;
                                now_next     = req.payload.now_time;
                                step_next    = count_reg - CNT_W'(1);
                                removed_next = '0;
                                state_next   = S_PURGE;
                            end
                        end
                    endcase
                    rsp_new.queue_length = 5'(count_next);
                end
            end
            S_PURGE:
            begin
                // rotate cells 1..tail, recirculate a survivor into the tail
                ctl.op      = tfq_pkg::CELL_PURGE;
                ctl.pos     = tfq_pkg::POS_W'(count_reg - CNT_W'(1));
                ctl.survive = survive;
                if (!survive)
                begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end
                step_next = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    rsp_load              = 1'b1;
                    rsp_new.queue_length  = 5'(count_next);
                    rsp_new.removed_count = 4'(removed_next);
                    state_next            = S_IDLE;
                end
            end
        endcase

        rsp_data_next = rsp_load ? rsp_new : rsp_data_reg;
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            removed_reg   <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            removed_reg   <= removed_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Row of cells: each cell takes from its upper neighbor on a shift
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        tfq_pkg::tfq_entry_t upper;
        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign upper = cell_q[i];
        end
        else
        begin : g_mid
            assign upper = cell_q[i + 1];
        end

        tfq_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .push_data (push_data),
            .neighbor  (upper),
            .recirc    (cell_q[1]),
            .entry     (cell_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound : assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_purge_blocks_req : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_PURGE) |-> (!req.ready && (step_reg != '0)))
        else $error("request taken or step count empty during purge");

    a_purge_needs_two : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && state_next == S_PURGE) |-> (count_reg >= CNT_W'(2)))
        else $error("purge rotation started on a short queue");

    a_full_length : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == tfq_pkg::STATUS_FULL)
            |-> (rsp_data_reg.queue_length == 5'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

endmodule

`default_nettype wire

FILE: rtl/tfq_cell.sv
// ----------------------------------------------------------------------------
// tfq_cell: one queue position
// Holds one entry and loads from the push data, its upper neighbor or the
// recirculated entry, as the broadcast control selects.
// ----------------------------------------------------------------------------
`default_nettype none

module tfq_cell #(
    parameter int IDX = 0
) (
    input  wire                    clk,
    input  tfq_pkg::tfq_cell_ctl_t ctl,
    input  tfq_pkg::tfq_entry_t    push_data,
    input  tfq_pkg::tfq_entry_t    neighbor,
    input  tfq_pkg::tfq_entry_t    recirc,
    output tfq_pkg::tfq_entry_t    entry
);

    localparam logic [tfq_pkg::POS_W-1:0] MY_POS = tfq_pkg::POS_W'(IDX);

    tfq_pkg::tfq_entry_t entry_reg;
    tfq_pkg::tfq_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            tfq_pkg::CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            tfq_pkg::CELL_PUSH:
            begin
                if (ctl.pos == MY_POS)
                begin
                    entry_next = push_data;
                end
            end
            tfq_pkg::CELL_SHIFT:
            begin
                entry_next = neighbor;
            end
            tfq_pkg::CELL_PURGE:
            begin
                // head position stays put during a purge
                if (IDX != 0)
                begin
                    if (ctl.survive && (ctl.pos == MY_POS))
                    begin
                        entry_next = recirc;
                    end
                    else
                    begin
                        entry_next = neighbor;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: test/timestamped_fifo_with_expiry_purge_tb.sv
// ----------------------------------------------------------------------------
// timestamped_fifo_with_expiry_purge_tb: self-checking bench for the queue
// The bench opens with a table of directed operations: empty queue, the full
// queue, field extremes and a purge across a wrapped clock. Random traffic
// follows in phases, each writing a new max_wait and using one of four idle
// patterns. A mirror of the queue predicts every response the table does not
// give, and the responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module timestamped_fifo_with_expiry_purge_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_ITEMS  = 100;
    localparam int SETTLE_TICKS = 32;

    typedef struct {
        bit                 is_cfg;
        logic [31:0]        cfg_value;
        tfq_pkg::tfq_req_t  req;
        bit                 typed;
        tfq_pkg::tfq_rsp_t  rsp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tfq_stream_if #(.payload_t(tfq_pkg::tfq_req_t)) req_if ();
    tfq_stream_if #(.payload_t(tfq_pkg::tfq_rsp_t)) rsp_if ();
    tfq_stream_if #(.payload_t(logic [31:0]))       cfg_if ();

    timestamped_fifo_with_expiry_purge #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if),
        .cfg  (cfg_if)
    );

    // Mirror of the queue: head in slot 0, kept compacted
    logic [31:0] mirror_arrival [DEPTH];
    logic [15:0] mirror_articles[DEPTH];
    int          mirror_count;
    logic [31:0] mirror_max_wait;

    // Responses still owed by the block, oldest first
    tfq_pkg::tfq_rsp_t awaited_replies[$];
    stim_row_t         directed_rows[$];

    int          error_count;
    int          tx_gap_max;
    int          rx_stall_max;
    logic [31:0] time_base;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Give up after far longer than the slowest legal run could take
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Queue mirror: apply one operation, return the response it causes
    // ------------------------------------------------------------------
    function automatic tfq_pkg::tfq_rsp_t apply_queue_op(tfq_pkg::tfq_req_t r);
        tfq_pkg::tfq_rsp_t o;
        int                keep;
        int                gone;
        logic [31:0]       age;
        o    = '0;
        gone = 0;
        case (r.mode)
            tfq_pkg::MODE_PUSH:
            begin
                if (mirror_count >= DEPTH)
                    o.status = tfq_pkg::STATUS_FULL;
                else
                begin
                    mirror_arrival[mirror_count]  = r.arrival_time;
                    mirror_articles[mirror_count] = r.article_count;
                    mirror_count++;
                end
            end
            tfq_pkg::MODE_POP, tfq_pkg::MODE_PEEK:
            begin
                if (mirror_count == 0)
                    o.status = tfq_pkg::STATUS_EMPTY;
                else
                begin
                    o.head_arrival  = mirror_arrival[0];
                    o.head_articles = mirror_articles[0];
                    if (r.mode == tfq_pkg::MODE_POP)
                    begin
                        for (int i = 1; i < mirror_count; i++)
                        begin
                            mirror_arrival[i-1]  = mirror_arrival[i];
                            mirror_articles[i-1] = mirror_articles[i];
                        end
                        mirror_count--;
                    end
                end
            end
            default:
            begin
                // The head always survives; compact the survivors behind it
                if (mirror_count >= 2)
                begin
                    keep = 1;
                    for (int rd = 1; rd < mirror_count; rd++)
                    begin
                        age = r.now_time - mirror_arrival[rd];
                        if (age >= mirror_max_wait)
                            gone++;
                        else
                        begin
                            mirror_arrival[keep]  = mirror_arrival[rd];
                            mirror_articles[keep] = mirror_articles[rd];
                            keep++;
                        end
                    end
                    mirror_count = keep;
                end
            end
        endcase
        o.queue_length  = mirror_count[4:0];
        o.removed_count = gone[3:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------
    function automatic tfq_pkg::tfq_req_t mk_req(logic [1:0] mode, logic [31:0] arr,
                                                 logic [15:0] art, logic [31:0] now);
        tfq_pkg::tfq_req_t r;
        r.mode          = mode;
        r.arrival_time  = arr;
        r.article_count = art;
        r.now_time      = now;
        return r;
    endfunction

    function automatic tfq_pkg::tfq_rsp_t mk_rsp(logic [1:0] st, logic [31:0] ha,
                                                 logic [15:0] hc, logic [4:0] len,
                                                 logic [3:0] rem);
        tfq_pkg::tfq_rsp_t o;
        o.status        = st;
        o.head_arrival  = ha;
        o.head_articles = hc;
        o.queue_length  = len;
        o.removed_count = rem;
        return o;
    endfunction

    function automatic void add_op(tfq_pkg::tfq_req_t r, bit typed,
                                   tfq_pkg::tfq_rsp_t o);
        stim_row_t row;
        row.is_cfg    = 1'b0;
        row.cfg_value = '0;
        row.req       = r;
        row.typed     = typed;
        row.rsp       = o;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [31:0] v);
        stim_row_t row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_value = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        tfq_pkg::tfq_rsp_t none;
        none = '0;
        // Empty queue right after reset, max_wait still 0
        add_op(mk_req(tfq_pkg::MODE_POP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF), 1,
               mk_rsp(tfq_pkg::STATUS_EMPTY, '0, '0, 5'd0, 4'd0));
        add_op(mk_req(tfq_pkg::MODE_PEEK, '0, '0, '0), 1,
               mk_rsp(tfq_pkg::STATUS_EMPTY, '0, '0, 5'd0, 4'd0));
        add_op(mk_req(tfq_pkg::MODE_PURGE, '0, '0, 32'hFFFF_FFFF), 1,
               mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'd0, 4'd0));
        // One entry: purge cannot touch the head
        add_op(mk_req(tfq_pkg::MODE_PUSH, 32'hFFFF_FFFF, 16'hFFFF, '0), 1,
               mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'd1, 4'd0));
        add_op(mk_req(tfq_pkg::MODE_PURGE, '0, '0, '0), 1,
               mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'd1, 4'd0));
        add_op(mk_req(tfq_pkg::MODE_PEEK, '0, '0, '0), 1,
               mk_rsp(tfq_pkg::STATUS_OK, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 4'd0));
        add_op(mk_req(tfq_pkg::MODE_POP, '0, '0, '0), 1,
               mk_rsp(tfq_pkg::STATUS_OK, 32'hFFFF_FFFF, 16'hFFFF, 5'd0, 4'd0));
        // Fill to the top, then overflow once
        for (int k = 0; k < DEPTH; k++)
            add_op(mk_req(tfq_pkg::MODE_PUSH, 32'(k * 32'h1111_1111),
                          16'(k * 16'h1111), '0), 1,
                   mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'(k + 1), 4'd0));
        add_op(mk_req(tfq_pkg::MODE_PUSH, 32'hDEAD_BEEF, 16'h5A5A, '0), 1,
               mk_rsp(tfq_pkg::STATUS_FULL, '0, '0, 5'd16, 4'd0));
        // max_wait of 0 expires every non-head entry
        add_op(mk_req(tfq_pkg::MODE_PURGE, '0, '0, 32'h1234_5678), 1,
               mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'd1, 4'd15));
        add_op(mk_req(tfq_pkg::MODE_POP, '0, '0, '0), 1,
               mk_rsp(tfq_pkg::STATUS_OK, '0, '0, 5'd0, 4'd0));
        // Purge across a clock that wrapped past zero
        add_cfg(32'd100);
        add_op(mk_req(tfq_pkg::MODE_PUSH, 32'd1000, 16'd5, '0), 0, none);
        add_op(mk_req(tfq_pkg::MODE_PUSH, 32'hFFFF_FFF0, 16'd6, '0), 0, none);
        add_op(mk_req(tfq_pkg::MODE_PUSH, 32'd10, 16'd7, '0), 0, none);
        add_op(mk_req(tfq_pkg::MODE_PURGE, '0, '0, 32'd5), 0, none);
        add_op(mk_req(tfq_pkg::MODE_PEEK, '0, '0, '0), 0, none);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge of the transfer
    task automatic send_request(tfq_pkg::tfq_req_t r, bit typed,
                                tfq_pkg::tfq_rsp_t typed_rsp);
        int                gap;
        tfq_pkg::tfq_rsp_t predicted;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        // Advance the mirror on every transfer, typed rows included
        predicted = apply_queue_op(r);
        awaited_replies.push_back(typed ? typed_rsp : predicted);
    endtask

    // Drop valid and hold until every owed response has been taken
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
    endtask

    task automatic write_max_wait(logic [31:0] v);
        wait_drained();
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= v;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid    <= 1'b0;
        mirror_max_wait  = v;
    endtask

    function automatic logic [31:0] phase_max_wait(int p);
        case (p)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            5:       return $urandom;
            8:       return 32'h8000_0000;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    // Mostly timestamps from a running clock so waits land near max_wait;
    // now and then full-range values to reach every bit and the wrap case
    function automatic tfq_pkg::tfq_req_t draw_request(int push_pct);
        tfq_pkg::tfq_req_t r;
        int                pick;
        time_base += $urandom_range(0, 40);
        if ($urandom_range(0, 99) < push_pct)
            r.mode = tfq_pkg::MODE_PUSH;
        else
        begin
            pick = $urandom_range(0, 2);
            r.mode = (pick == 0) ? tfq_pkg::MODE_POP :
                     (pick == 1) ? tfq_pkg::MODE_PEEK : tfq_pkg::MODE_PURGE;
        end
        r.article_count = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 15)
        begin
            r.arrival_time = $urandom;
            r.now_time     = $urandom;
        end
        else
        begin
            r.arrival_time = time_base;
            r.now_time     = time_base;
        end
        return r;
    endfunction

    initial
    begin
        tfq_pkg::tfq_req_t r;
        tfq_pkg::tfq_rsp_t unused;
        int                push_pct;

        // Hold every block input at a known value from time zero
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        error_count     = 0;
        mirror_count    = 0;
        mirror_max_wait = '0;
        tx_gap_max      = 16;
        rx_stall_max    = 16;
        unused          = '0;
        // Start near the top of the 32-bit range so the clock wraps early
        time_base = 32'hFFFF_F000 + $urandom_range(0, 4000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_max_wait(directed_rows[i].cfg_value);
            else
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].rsp);
        end

        // Random phases: new max_wait and idle pattern in each
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_max_wait(phase_max_wait(p));
            case (p % 4)
                0:
                begin
                    tx_gap_max   = 16;
                    rx_stall_max = 16;
                end
                1:
                begin
                    tx_gap_max   = 0;
                    rx_stall_max = 0;
                end
                2:
                begin
                    tx_gap_max   = 0;
                    rx_stall_max = 16;
                end
                default:
                begin
                    tx_gap_max   = 16;
                    rx_stall_max = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Alternate filling and draining stretches
                push_pct = ((i / 25) % 2 == 0) ? 70 : 30;
                // Pause mid-run until the block has answered everything
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_drained();
                r = draw_request(push_pct);
                send_request(r, 1'b0, unused);
            end
        end

        // Drain, then give the block time to show any stray response
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            $error("responses never arrived: %0d", awaited_replies.size());
            error_count++;
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    initial
    begin
        int                stall;
        tfq_pkg::tfq_rsp_t want;
        tfq_pkg::tfq_rsp_t got;

        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
            got = rsp_if.payload;
            if (awaited_replies.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("head_arrival", want.head_arrival, got.head_arrival);
                check_field("head_articles", 32'(want.head_articles),
                            32'(got.head_articles));
                check_field("queue_length", 32'(want.queue_length),
                            32'(got.queue_length));
                check_field("removed_count", 32'(want.removed_count),
                            32'(got.removed_count));
            end
        end
    end

endmodule

FILE: files.f
rtl/tfq_pkg.sv
rtl/tfq_stream_if.sv
rtl/tfq_cell.sv
rtl/timestamped_fifo_with_expiry_purge.sv
test/timestamped_fifo_with_expiry_purge_tb.sv
